### rtl/ufrc_pkg.sv
package ufrc_pkg;

    // Frame layout and the byte values that the classifier matches.
    localparam logic [7:0] START_BYTE    = 8'hFB;
    localparam logic [7:0] MAX_FRAME     = 8'd32;
    localparam logic [7:0] COUNT_MAX     = 8'hFF;

    localparam logic [7:0] OFF_LENGTH    = 8'd1;
    localparam logic [7:0] OFF_STYLE     = 8'd9;
    localparam logic [7:0] OFF_SUBTYPE   = 8'd10;
    localparam logic [7:0] OFF_SUBCODE   = 8'd11;
    localparam logic [7:0] OFF_ACK_STAT  = 8'd13;
    localparam logic [7:0] OFF_VALUE     = 8'd14;

    localparam logic [7:0] ALERT_STYLE   = 8'h02;
    localparam logic [7:0] ALERT_SUBTYPE = 8'h06;
    localparam logic [7:0] ALERT_MIN     = 8'h01;
    localparam logic [7:0] ALERT_MAX     = 8'h04;
    localparam logic [7:0] ACK_STYLE     = 8'h12;
    localparam logic [7:0] ACK_SUBTYPE   = 8'h04;
    localparam logic [7:0] ACK_SUBCODE   = 8'h02;
    localparam logic [7:0] ACK_OK        = 8'h00;

    typedef enum logic [2:0] {
        ST_OTHER     = 3'd0,
        ST_ALERT     = 3'd1,
        ST_ACK       = 3'd2,
        ST_CSUM_ERR  = 3'd3,
        ST_OVERSIZE  = 3'd4
    } status_t;

endpackage

### rtl/uart_frame_receiver_classifier.sv
// Receives UART bytes and reports one classification word per completed frame.
// The input channel (s_valid, s_ready, s_rx_byte) takes one byte per word. A
// 0xFB byte restarts a frame, the byte at offset 1 is the frame length, and an
// 8-bit running sum covers every byte of the frame.
// The result channel (m_valid, m_ready, m_status, m_alert_code, m_presence,
// m_frame_length) carries one word for each frame whose byte count reaches its
// length.
// Throughput is one byte per cycle while s_ready is high: every byte is handled
// in the cycle in which it is accepted, from the count, sum and five captured
// frame bytes. The result word is valid in the cycle after the last byte of the
// frame is accepted.
// A single output register holds the result word. While it is full and
// m_ready is low, s_ready is low and no byte is taken.
// Reset clears the byte count, running sum, length, output valid and
// calibration mode. cfg_we writes calibration mode, which suppresses fatigue alerts;
// the user writes it only while the block is idle; the block does not enforce it.
module uart_frame_receiver_classifier (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [2:0] m_alert_code,
    output logic [7:0] m_presence,
    output logic [7:0] m_frame_length
);

    logic                 calib_reg;
    logic [7:0]           count_reg, count_next;
    logic [7:0]           length_reg, length_next;
    logic                 captured_reg, captured_next;
    logic [7:0]           sum_reg, sum_next;
    logic [7:0]           style_reg, style_next;
    logic [7:0]           subtype_reg, subtype_next;
    logic [7:0]           subcode_reg, subcode_next;
    logic [7:0]           ack_stat_reg, ack_stat_next;
    logic [7:0]           value_reg, value_next;

    logic                 m_valid_reg, m_valid_next;
    ufrc_pkg::status_t    status_reg, status_next;
    logic [2:0]           code_reg, code_next;
    logic [7:0]           presence_reg, presence_next;
    logic [7:0]           flen_reg;

    logic                 accept;
    logic                 start;
    logic                 done;
    logic [7:0]           offset;
    logic [7:0]           fb_style, fb_subtype, fb_subcode, fb_ack_stat, fb_value;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        start  = (s_rx_byte == ufrc_pkg::START_BYTE);
        offset = start ? 8'd0 : count_reg;

        length_next   = (offset == ufrc_pkg::OFF_LENGTH) ? s_rx_byte : length_reg;
        captured_next = (offset == ufrc_pkg::OFF_LENGTH) || (!start && captured_reg);
        sum_next      = (start ? 8'd0 : sum_reg) + s_rx_byte;
        count_next    = (offset == ufrc_pkg::COUNT_MAX) ? ufrc_pkg::COUNT_MAX
                                                        : offset + 8'd1;

        style_next    = (offset == ufrc_pkg::OFF_STYLE)    ? s_rx_byte : style_reg;
        subtype_next  = (offset == ufrc_pkg::OFF_SUBTYPE)  ? s_rx_byte : subtype_reg;
        subcode_next  = (offset == ufrc_pkg::OFF_SUBCODE)  ? s_rx_byte : subcode_reg;
        ack_stat_next = (offset == ufrc_pkg::OFF_ACK_STAT) ? s_rx_byte : ack_stat_reg;
        value_next    = (offset == ufrc_pkg::OFF_VALUE)    ? s_rx_byte : value_reg;

        done = captured_next && (count_next == length_next);

        // Bytes at offsets past the end of the frame read as zero.
        fb_style    = (ufrc_pkg::OFF_STYLE    < length_next) ? style_next    : 8'h00;
        fb_subtype  = (ufrc_pkg::OFF_SUBTYPE  < length_next) ? subtype_next  : 8'h00;
        fb_subcode  = (ufrc_pkg::OFF_SUBCODE  < length_next) ? subcode_next  : 8'h00;
        fb_ack_stat = (ufrc_pkg::OFF_ACK_STAT < length_next) ? ack_stat_next : 8'h00;
        fb_value    = (ufrc_pkg::OFF_VALUE    < length_next) ? value_next    : 8'h00;

        status_next   = ufrc_pkg::ST_OTHER;
        code_next     = 3'd0;
        presence_next = 8'h00;
        if (length_next > ufrc_pkg::MAX_FRAME) begin
            status_next = ufrc_pkg::ST_OVERSIZE;
        end else if (sum_next != 8'h00) begin
            status_next = ufrc_pkg::ST_CSUM_ERR;
        end else if (fb_style == ufrc_pkg::ALERT_STYLE
                     && fb_subtype == ufrc_pkg::ALERT_SUBTYPE
                     && fb_value >= ufrc_pkg::ALERT_MIN
                     && fb_value <= ufrc_pkg::ALERT_MAX
                     && !calib_reg) begin
            status_next = ufrc_pkg::ST_ALERT;
            code_next   = fb_value[2:0];
        end else if (fb_style == ufrc_pkg::ACK_STYLE
                     && fb_subtype == ufrc_pkg::ACK_SUBTYPE
                     && fb_subcode == ufrc_pkg::ACK_SUBCODE
                     && fb_ack_stat == ufrc_pkg::ACK_OK) begin
            status_next   = ufrc_pkg::ST_ACK;
            presence_next = fb_value;
        end

        if (accept && done) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calib_reg    <= 1'b0;
            count_reg    <= 8'd0;
            length_reg   <= 8'd0;
            captured_reg <= 1'b0;
            sum_reg      <= 8'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                calib_reg <= cfg_wdata;
            end
            if (accept) begin
                count_reg    <= count_next;
                length_reg   <= length_next;
                captured_reg <= captured_next && !done;
                sum_reg      <= sum_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            style_reg    <= style_next;
            subtype_reg  <= subtype_next;
            subcode_reg  <= subcode_next;
            ack_stat_reg <= ack_stat_next;
            value_reg    <= value_next;
        end
        if (accept && done) begin
            status_reg   <= status_next;
            code_reg     <= code_next;
            presence_reg <= presence_next;
            flen_reg     <= length_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_alert_code   = code_reg;
    assign m_presence     = presence_reg;
    assign m_frame_length = flen_reg;

endmodule

### rtl/ufrc_checker.sv
module ufrc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       cfg_we,
    input logic       cfg_wdata,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_rx_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_status,
    input logic [2:0] m_alert_code,
    input logic [7:0] m_presence,
    input logic [7:0] m_frame_length
);

    // A stalled result word keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_alert_code)
            && $stable(m_presence) && $stable(m_frame_length))
        else $error("stalled result word changed");

    // Reset empties the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // With no result word waiting, the input is always ready.
    assert property (@(posedge aclk) disable iff (!aresetn) !m_valid |-> s_ready)
        else $error("input stalled while output register empty");

    // An alert word carries a level from one to four and no presence byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ufrc_pkg::ST_ALERT |->
            m_alert_code >= 3'd1 && m_alert_code <= 3'd4 && m_presence == 8'h00)
        else $error("alert word with bad level or presence");

    // Only alert words carry a level and only ack words carry a presence byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ufrc_pkg::ST_ALERT |->
            m_alert_code == 3'd0
            && (m_status == ufrc_pkg::ST_ACK || m_presence == 8'h00))
        else $error("level or presence set on the wrong class");

endmodule

bind uart_frame_receiver_classifier ufrc_checker u_ufrc_checker (.*);

### test/frame_checker.sv
`timescale 1ns / 100ps

module frame_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [2:0] m_status,
    input  logic [2:0] m_alert_code,
    input  logic [7:0] m_presence,
    input  logic [7:0] m_frame_length,
    output int         errors,
    output int         pending
);

    localparam int STORE_DEPTH = 32;

    typedef struct packed {
        ufrc_pkg::status_t status;
        logic [2:0]        alert_code;
        logic [7:0]        presence;
        logic [7:0]        frame_length;
    } frame_word_t;

    frame_word_t expected_q[$];
    logic        calib;
    logic [7:0]  byte_cnt;
    logic [7:0]  len_byte;
    logic        len_seen;
    logic [7:0]  run_sum;
    logic [7:0]  frame_mem [0:STORE_DEPTH-1];

    // Offsets past the frame end, or past the store, read as zero.
    function automatic logic [7:0] byte_at(input logic [7:0] off);
        if (off >= len_byte || off >= STORE_DEPTH) begin
            return 8'h00;
        end
        return frame_mem[off[4:0]];
    endfunction

    task automatic absorb_byte(input logic [7:0] b);
        frame_word_t w;
        logic [7:0]  style;
        logic [7:0]  value;
        if (b == ufrc_pkg::START_BYTE) begin
            byte_cnt = 8'd0;
            run_sum  = 8'd0;
            len_seen = 1'b0;
        end
        if (byte_cnt == ufrc_pkg::OFF_LENGTH) begin
            len_byte = b;
            len_seen = 1'b1;
        end
        if (byte_cnt < STORE_DEPTH) begin
            frame_mem[byte_cnt[4:0]] = b;
        end
        run_sum = run_sum + b;
        if (byte_cnt != ufrc_pkg::COUNT_MAX) begin
            byte_cnt = byte_cnt + 8'd1;
        end
        if (len_seen && byte_cnt == len_byte) begin
            len_seen       = 1'b0;
            w.status       = ufrc_pkg::ST_OTHER;
            w.alert_code   = 3'd0;
            w.presence     = 8'h00;
            w.frame_length = len_byte;
            style          = byte_at(ufrc_pkg::OFF_STYLE);
            value          = byte_at(ufrc_pkg::OFF_VALUE);
            if (len_byte > ufrc_pkg::MAX_FRAME) begin
                w.status = ufrc_pkg::ST_OVERSIZE;
            end else if (run_sum != 8'd0) begin
                w.status = ufrc_pkg::ST_CSUM_ERR;
            end else if (style == ufrc_pkg::ALERT_STYLE &&
                         byte_at(ufrc_pkg::OFF_SUBTYPE) == ufrc_pkg::ALERT_SUBTYPE &&
                         value >= ufrc_pkg::ALERT_MIN && value <= ufrc_pkg::ALERT_MAX &&
                         !calib) begin
                w.status     = ufrc_pkg::ST_ALERT;
                w.alert_code = value[2:0];
            end else if (style == ufrc_pkg::ACK_STYLE &&
                         byte_at(ufrc_pkg::OFF_SUBTYPE) == ufrc_pkg::ACK_SUBTYPE &&
                         byte_at(ufrc_pkg::OFF_SUBCODE) == ufrc_pkg::ACK_SUBCODE &&
                         byte_at(ufrc_pkg::OFF_ACK_STAT) == ufrc_pkg::ACK_OK) begin
                w.status   = ufrc_pkg::ST_ACK;
                w.presence = value;
            end
            expected_q.push_back(w);
        end
    endtask

    task automatic check_word();
        frame_word_t e;
        if (expected_q.size() == 0) begin
            $error("result word with no frame pending: status %0d length %0d",
                   m_status, m_frame_length);
            errors++;
        end else begin
            e = expected_q.pop_front();
            if (m_status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, m_status);
                errors++;
            end
            if (m_alert_code !== e.alert_code) begin
                $error("alert_code: expected %0d, actual %0d", e.alert_code, m_alert_code);
                errors++;
            end
            if (m_presence !== e.presence) begin
                $error("presence: expected %0d, actual %0d", e.presence, m_presence);
                errors++;
            end
            if (m_frame_length !== e.frame_length) begin
                $error("frame_length: expected %0d, actual %0d",
                       e.frame_length, m_frame_length);
                errors++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_q.delete();
            calib    = 1'b0;
            byte_cnt = 8'd0;
            len_byte = 8'd0;
            len_seen = 1'b0;
            run_sum  = 8'd0;
            errors   = 0;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                frame_mem[i] = 8'h00;
            end
        end else begin
            if (m_valid && m_ready) begin
                check_word();
            end
            if (cfg_we) begin
                calib = cfg_wdata;
            end
            if (s_valid && s_ready) begin
                absorb_byte(s_rx_byte);
            end
        end
        pending <= expected_q.size();
    end

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int FK_PLAIN    = 0;
    localparam int FK_ALERT    = 1;
    localparam int FK_ACK      = 2;
    localparam int HOLD_CYCLES = 200;

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_rx_byte;
    logic       m_valid;
    logic       m_ready;
    logic [2:0] m_status;
    logic [2:0] m_alert_code;
    logic [7:0] m_presence;
    logic [7:0] m_frame_length;
    int         errors;
    int         pending;
    int         bytes_sent;
    bit         hold_req;
    bit         ready_steady;
    bit         gaps_off;
    logic [7:0] frame_buf [0:255];

    uart_frame_receiver_classifier DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_alert_code   (m_alert_code),
        .m_presence     (m_presence),
        .m_frame_length (m_frame_length)
    );

    frame_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_alert_code   (m_alert_code),
        .m_presence     (m_presence),
        .m_frame_length (m_frame_length),
        .errors         (errors),
        .pending        (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == ufrc_pkg::START_BYTE);
        return b;
    endfunction

    task automatic put_byte(input logic [7:0] b);
        int gap;
        gap = gaps_off ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Builds a frame of the given kind, with a correct checksum for lengths of three
    // or more unless told otherwise, then sends its first upto bytes.
    task automatic send_frame(input int kind, input int len, input bit bad_sum, input int upto);
        int         n;
        logic [7:0] acc;
        logic [7:0] cs;
        logic [7:0] wrong;
        n = (len < 2) ? 2 : len;
        for (int i = 0; i < n; i++) begin
            frame_buf[i] = body_byte();
        end
        frame_buf[0] = ufrc_pkg::START_BYTE;
        frame_buf[1] = len[7:0];
        if (kind == FK_ALERT) begin
            frame_buf[ufrc_pkg::OFF_STYLE]   = ufrc_pkg::ALERT_STYLE;
            frame_buf[ufrc_pkg::OFF_SUBTYPE] = ($urandom_range(0, 9) == 0) ?
                                               body_byte() : ufrc_pkg::ALERT_SUBTYPE;
            frame_buf[ufrc_pkg::OFF_VALUE]   = ($urandom_range(0, 9) < 8) ?
                                               8'($urandom_range(1, 4)) : body_byte();
        end else if (kind == FK_ACK) begin
            frame_buf[ufrc_pkg::OFF_STYLE]    = ufrc_pkg::ACK_STYLE;
            frame_buf[ufrc_pkg::OFF_SUBTYPE]  = ufrc_pkg::ACK_SUBTYPE;
            frame_buf[ufrc_pkg::OFF_SUBCODE]  = ufrc_pkg::ACK_SUBCODE;
            frame_buf[ufrc_pkg::OFF_ACK_STAT] = ($urandom_range(0, 9) == 0) ?
                                                body_byte() : ufrc_pkg::ACK_OK;
            frame_buf[ufrc_pkg::OFF_VALUE]    = body_byte();
        end
        if (len >= 3) begin
            do begin
                acc = 8'd0;
                for (int i = 0; i < len - 1; i++) begin
                    acc = acc + frame_buf[i];
                end
                cs = -acc;
                if (cs == ufrc_pkg::START_BYTE) begin
                    frame_buf[2] = body_byte();
                end
            end while (cs == ufrc_pkg::START_BYTE);
            if (bad_sum) begin
                do begin
                    wrong = cs + 8'($urandom_range(1, 255));
                end while (wrong == ufrc_pkg::START_BYTE);
                cs = wrong;
            end
            frame_buf[len-1] = cs;
        end
        for (int i = 0; i < upto && i < n; i++) begin
            put_byte(frame_buf[i]);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_calib(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(input int stop_at);
        int r;
        int kind;
        int len;
        while (bytes_sent < stop_at) begin
            r    = $urandom_range(0, 99);
            kind = $urandom_range(FK_PLAIN, FK_ACK);
            if (r < 30) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 15) : $urandom_range(15, 32);
                send_frame(FK_PLAIN, len, 1'b0, 256);
            end else if (r < 50) begin
                send_frame(FK_ALERT, $urandom_range(15, 32), 1'b0, 256);
            end else if (r < 68) begin
                send_frame(FK_ACK, $urandom_range(14, 32), 1'b0, 256);
            end else if (r < 74) begin
                send_frame(kind, $urandom_range(3, 32), 1'b1, 256);
            end else if (r < 80) begin
                len = ($urandom_range(0, 14) == 0) ? $urandom_range(200, 255) :
                                                     $urandom_range(33, 48);
                if (len == ufrc_pkg::START_BYTE) begin
                    len = 250;
                end
                send_frame(kind, len, 1'($urandom_range(0, 1)), 256);
            end else if (r < 88) begin
                len = $urandom_range(4, 32);
                send_frame(kind, len, 1'b0, $urandom_range(1, len - 1));
            end else if (r < 92) begin
                send_frame(kind, $urandom_range(0, 8), 1'($urandom_range(0, 1)), 256);
            end else begin
                repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        int n;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (ready_steady || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                n = pick_gap();
                repeat (n) @(posedge aclk);
            end
        end
    end

    initial begin
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        s_valid      = 1'b0;
        s_rx_byte    = 8'h00;
        bytes_sent   = 0;
        hold_req     = 1'b0;
        ready_steady = 1'b0;
        gaps_off     = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        write_calib(1'b0);

        // Bytes ahead of any start byte form a frame counted from reset.
        put_byte(8'h05);
        put_byte(8'h03);
        put_byte(8'hF8);
        send_frame(FK_PLAIN, 2, 1'b0, 256);
        put_byte(ufrc_pkg::START_BYTE);
        send_frame(FK_PLAIN, 2, 1'b0, 256);
        send_frame(FK_PLAIN, 0, 1'b0, 256);
        send_frame(FK_PLAIN, 1, 1'b0, 256);
        send_frame(FK_PLAIN, 3, 1'b0, 256);
        put_byte(8'h00);
        put_byte(8'hFF);
        send_frame(FK_ALERT, 15, 1'b0, 256);
        send_frame(FK_ALERT, 32, 1'b0, 256);
        send_frame(FK_ACK, 16, 1'b0, 256);
        send_frame(FK_ACK, 14, 1'b0, 256);
        send_frame(FK_ACK, 32, 1'b1, 256);
        send_frame(FK_PLAIN, 33, 1'b0, 256);
        send_frame(FK_PLAIN, 255, 1'b0, 256);
        send_frame(FK_PLAIN, 0, 1'b0, 256);
        repeat (300) put_byte(body_byte());
        send_frame(FK_ACK, 20, 1'b0, 256);
        drain();
        write_calib(1'b1);
        send_frame(FK_ALERT, 15, 1'b0, 256);
        send_frame(FK_ALERT, 24, 1'b0, 256);
        send_frame(FK_ACK, 18, 1'b0, 256);
        drain();
        write_calib(1'b0);

        // The receiver stalls while short frames keep arriving, so the block backs up.
        hold_req = 1'b1;
        repeat (8) send_frame(FK_PLAIN, 2, 1'b0, 256);
        random_phase(bytes_sent + 230);
        drain();
        write_calib(1'b1);
        random_phase(bytes_sent + 230);
        drain();
        write_calib(1'b0);
        ready_steady = 1'b1;
        gaps_off     = 1'b1;
        random_phase(bytes_sent + 110);
        ready_steady = 1'b0;
        gaps_off     = 1'b0;
        random_phase(bytes_sent + 200);
        drain();

        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
